[hw/rtl/sir_pkg.sv]
package sir_pkg;

   // Frame geometry and filter limits
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int MAX_TAPS    = 17;
   localparam int CHANNELS    = 3;
   localparam int X_W         = $clog2(MAX_WIDTH);
   localparam int Y_W         = $clog2(MAX_HEIGHT);
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int TAP_W       = $clog2(MAX_TAPS + 1);
   localparam int TIDX_W      = $clog2(MAX_TAPS);
   localparam int PIX_W       = 16;

   // Shared divider widths
   localparam int DIVD_W = 48;
   localparam int DIVS_W = 21;

   // Divider operand selection
   localparam logic [1:0] DIV_SRC = 2'd0;
   localparam logic [1:0] DIV_KSZ = 2'd1;
   localparam logic [1:0] DIV_ROW = 2'd2;
   localparam logic [1:0] DIV_COL = 2'd3;

   // Weight unit steps
   localparam logic [2:0] WS_DIST  = 3'd0;
   localparam logic [2:0] WS_SCALE = 3'd1;
   localparam logic [2:0] WS_SQ    = 3'd2;
   localparam logic [2:0] WS_CUBE  = 3'd3;
   localparam logic [2:0] WS_STORE = 3'd4;

   typedef struct packed {
      logic              write;
      logic              capture;
      logic              out_load;
      logic              out_zero;
      logic              div_start;
      logic              div_take;
      logic [1:0]        div_sel;
      logic              axis;
      logic              begin_load;
      logic              w_en;
      logic [2:0]        wstep;
      logic              rd_issue;
      logic              col_mac;
      logic [TAP_W-1:0]  tap;
      logic [TAP_W-1:0]  row;
   } sir_cmd_type;

   typedef struct packed {
      logic              ch_bad;
      logic              div_done;
      logic [TAP_W-1:0]  taps_x;
      logic [TAP_W-1:0]  taps_y;
   } sir_status_type;

endpackage

[hw/rtl/separable_image_resampler_core.sv]
// Separable image resampler. A source pixel write (req_kind 0) is taken in its
// accept cycle and busy stays low, so writes can stream every cycle while no
// query holds busy. A query (req_kind 1) raises busy until its result strobes on
// rsp_valid for one cycle; the receiver cannot stall, so rsp_pixel_out must be
// captured in that cycle. The result strobes in the same cycle that busy falls.
// The tap count per axis (2 to 17) is set by kernel and scale. The frame store
// has a single read port, so the taps of each row are read one at a time, and
// one shared divider at two quotient bits per cycle serves the source position,
// kernel size and every row and column normalization. A query on a channel
// outside the frame returns 0, going from the check state straight back to idle.
// Configuration writes on the csr_ channel are always ready and must only be
// issued while busy is low and no result is pending.
module separable_image_resampler_core import sir_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_kind,
   input  logic [11:0]      req_x_coord,
   input  logic [11:0]      req_y_coord,
   input  logic [1:0]       req_channel,
   input  logic [PIX_W-1:0] req_pixel_in,
   output logic             rsp_valid,
   output logic [PIX_W-1:0] rsp_pixel_out,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   sir_cmd_type    cmd;
   sir_status_type st;

   sir_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .kind  (req_kind),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   sir_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_x_coord   (req_x_coord),
      .req_y_coord   (req_y_coord),
      .req_channel   (req_channel),
      .req_pixel_in  (req_pixel_in),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .st            (st),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out)
   );

`ifndef ASSERT_OFF
   // Results are loaded only from busy states entered from idle, so result strobes never touch
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // A pixel write completes in its accept cycle
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_kind) |=> !busy)
      else $error("busy raised by a pixel write");

   // A query occupies the block after acceptance
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind) |=> busy)
      else $error("query accepted without going busy");

   // No result appears while idle without a query in flight
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a query in progress");
`endif

endmodule

[hw/rtl/sir_ram.sv]
module sir_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/sir_div.sv]
module sir_div import sir_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);

   // Restoring division, two quotient bits per cycle
   localparam int STEPS = DIVD_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DIVS_W:0]   rem_ff, rem_in;
   logic [DIVD_W-1:0] dq_ff, dq_in;
   logic [DIVS_W-1:0] d_ff;

   always_comb begin
      rem_in = rem_ff;
      dq_in  = dq_ff;
      for (int s = 0; s < 2; s++) begin
         rem_in = {rem_in[DIVS_W-1:0], dq_in[DIVD_W-1]};
         dq_in  = {dq_in[DIVD_W-2:0], 1'b0};
         if (rem_in >= {1'b0, d_ff}) begin
            rem_in   = rem_in - {1'b0, d_ff};
            dq_in[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand and working registers
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dq_ff  <= dividend;
         d_ff   <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

[hw/rtl/sir_datapath.sv]
module sir_datapath import sir_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [11:0]          req_x_coord,
   input  logic [11:0]          req_y_coord,
   input  logic [1:0]           req_channel,
   input  logic [PIX_W-1:0]     req_pixel_in,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   input  sir_cmd_type          cmd,
   output sir_status_type       st,
   output logic                 rsp_valid,
   output logic [PIX_W-1:0]     rsp_pixel_out
);

   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_SCALE  = 2'd1;
   localparam logic [1:0] CSR_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_HEIGHT = 2'd3;
   localparam logic [1:0] MODE_BOX   = 2'd0;
   localparam logic [1:0] MODE_TENT  = 2'd1;
   localparam logic [1:0] MODE_CUBIC = 2'd2;

   // Configuration registers
   logic [1:0]  mode_ff;
   logic [15:0] scale_ff;
   logic [8:0]  width_ff, height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_TENT;
         scale_ff  <= 16'd4096;
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:   mode_ff   <= csr_wdata[1:0];
            CSR_SCALE:  scale_ff  <= csr_wdata;
            CSR_WIDTH:  width_ff  <= csr_wdata[8:0];
            CSR_HEIGHT: height_ff <= csr_wdata[8:0];
         endcase
      end
   end

   // Effective kernel setup
   logic [1:0]     mode;
   logic [15:0]    ks_in;
   logic [12:0]    kscale;
   logic [12:0]    wcl, hcl;
   logic [X_W-1:0] wmax;
   logic [Y_W-1:0] hmax;

   always_comb begin
      mode   = (mode_ff > MODE_CUBIC) ? MODE_CUBIC : mode_ff;
      ks_in  = (scale_ff < 16'd1024) ? 16'd1024 : scale_ff;
      kscale = (ks_in > 16'd4096) ? 13'd4096 : ks_in[12:0];
      wcl    = (width_ff == 9'd0) ? 13'd1 :
               ({4'b0, width_ff} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {4'b0, width_ff};
      hcl    = (height_ff == 9'd0) ? 13'd1 :
               ({4'b0, height_ff} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'b0, height_ff};
      wmax   = X_W'(wcl - 13'd1);
      hmax   = Y_W'(hcl - 13'd1);
   end

   // Query capture
   logic [11:0] qx_ff, qy_ff;
   logic [1:0]  qch_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         qx_ff  <= req_x_coord;
         qy_ff  <= req_y_coord;
         qch_ff <= req_channel;
      end
   end

   // Frame store write path
   logic              wr_ok;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [PIX_W-1:0]  ram_rdata;

   assign wr_ok = cmd.write && ({1'b0, req_x_coord} < 13'(MAX_WIDTH)) &&
                  ({1'b0, req_y_coord} < 13'(MAX_HEIGHT)) &&
                  ({1'b0, req_channel} < 3'(CHANNELS));
   assign wr_addr = ADDR_W'({req_y_coord[Y_W-1:0], req_x_coord[X_W-1:0]} * CHANNELS
                            + req_channel);

   sir_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_store (
      .clock (clock),
      .we    (wr_ok),
      .waddr (wr_addr),
      .wdata (req_pixel_in),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   // Axis state
   logic [30:0]                src_ff;
   logic [19:0]                ksize_ff;
   logic signed [16:0]         bx_ff, by_ff;
   logic [TAP_W-1:0]           tx_ff, ty_ff;
   logic signed [20:0]         sx_ff, sy_ff;
   logic signed [15:0]         wx_ff [MAX_TAPS];
   logic signed [15:0]         wy_ff [MAX_TAPS];
   logic signed [23:0]         partial_ff [MAX_TAPS];

   // Begin position and tap count
   logic signed [32:0] bpos;
   logic [5:0]         taps_raw;
   logic [TAP_W-1:0]   taps_cap;

   always_comb begin
      bpos     = $signed({2'b0, src_ff}) - $signed({13'b0, ksize_ff}) + 33'sd32768;
      taps_raw = {1'b0, ksize_ff[19:15]} + 6'd1;
      taps_cap = (taps_raw > 6'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : TAP_W'(taps_raw);
   end

   // Weight unit
   logic [21:0]        ad_ff;
   logic [20:0]        a_ff;
   logic [17:0]        x2_ff;
   logic [18:0]        x3_ff;
   logic signed [17:0] wpos;
   logic signed [34:0] tap_off;
   logic [34:0]        off_mag;
   logic [34:0]        ka;
   logic [33:0]        sq;
   logic [34:0]        cu;
   logic signed [24:0] v2;
   logic signed [15:0] wval;

   always_comb begin
      wpos     = (cmd.axis ? $signed({by_ff[16], by_ff}) : $signed({bx_ff[16], bx_ff}))
                 + $signed({{(18 - TAP_W){1'b0}}, cmd.tap});
      tap_off  = $signed({wpos[17], wpos, 16'b0}) - $signed({4'b0, src_ff});
      off_mag  = tap_off[34] ? 35'(-tap_off) : 35'(tap_off);
      ka       = 35'(ad_ff * kscale);
      sq       = a_ff[16:0] * a_ff[16:0];
      cu       = x2_ff * a_ff[16:0];
      if (a_ff < 21'd65536) begin
         v2 = 25'sd3 * $signed({6'b0, x3_ff}) - 25'sd5 * $signed({7'b0, x2_ff}) + 25'sd131072;
      end else begin
         v2 = -$signed({6'b0, x3_ff}) + 25'sd5 * $signed({7'b0, x2_ff})
              - 25'sd8 * $signed({8'b0, a_ff[16:0]}) + 25'sd262144;
      end
      unique case (mode)
         MODE_BOX:  wval = (a_ff <= 21'd32768) ? 16'sd16384 : 16'sd0;
         MODE_TENT: wval = (a_ff < 21'd65536) ?
                           $signed(16'((21'd65536 - a_ff) >> 2)) : 16'sd0;
         default:   wval = (a_ff >= 21'd131072) ? 16'sd0 : 16'(v2 >>> 3);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.w_en) begin
         unique case (cmd.wstep)
            WS_DIST:  ad_ff <= off_mag[21:0];
            WS_SCALE: a_ff  <= ka[32:12];
            WS_SQ:    x2_ff <= sq[33:16];
            WS_CUBE:  x3_ff <= cu[34:16];
            WS_STORE: begin
               if (cmd.axis) begin
                  wy_ff[TIDX_W'(cmd.tap)] <= wval;
                  sy_ff <= sy_ff + 21'(wval);
               end else begin
                  wx_ff[TIDX_W'(cmd.tap)] <= wval;
                  sx_ff <= sx_ff + 21'(wval);
               end
            end
            default: ;
         endcase
      end
      if (cmd.begin_load) begin
         if (cmd.axis) begin
            by_ff <= bpos[32:16];
            ty_ff <= taps_cap;
            sy_ff <= '0;
         end else begin
            bx_ff <= bpos[32:16];
            tx_ff <= taps_cap;
            sx_ff <= '0;
         end
      end
   end

   // Edge-clamped read address
   logic signed [17:0] cpos, rpos;
   logic [X_W-1:0]     col;
   logic [Y_W-1:0]     row;

   always_comb begin
      cpos = $signed({bx_ff[16], bx_ff}) + $signed({{(18 - TAP_W){1'b0}}, cmd.tap});
      rpos = $signed({by_ff[16], by_ff}) + $signed({{(18 - TAP_W){1'b0}}, cmd.row});
      if (cpos < 0) begin
         col = '0;
      end else if (cpos > $signed({{(18 - X_W){1'b0}}, wmax})) begin
         col = wmax;
      end else begin
         col = cpos[X_W-1:0];
      end
      if (rpos < 0) begin
         row = '0;
      end else if (rpos > $signed({{(18 - Y_W){1'b0}}, hmax})) begin
         row = hmax;
      end else begin
         row = rpos[Y_W-1:0];
      end
      rd_addr = ADDR_W'({row, col} * CHANNELS + qch_ff);
   end

   // Multiply-accumulate: row taps from the store, column taps from partials
   logic                  rd_v_ff;
   logic [TAP_W-1:0]      tapd_ff;
   logic signed [15:0]    mac_w;
   logic signed [23:0]    mac_b;
   logic signed [39:0]    prod_ff;
   logic                  prod_v_ff;
   logic signed [45:0]    acc_ff;
   logic                  acc_clr;

   always_comb begin
      mac_w   = rd_v_ff ? wx_ff[TIDX_W'(tapd_ff)] : wy_ff[TIDX_W'(cmd.row)];
      mac_b   = rd_v_ff ? $signed({8'b0, ram_rdata}) : partial_ff[TIDX_W'(cmd.row)];
      acc_clr = (cmd.rd_issue && (cmd.tap == '0)) || (cmd.col_mac && (cmd.row == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.rd_issue;
         prod_v_ff <= rd_v_ff | cmd.col_mac;
      end
   end

   always_ff @(posedge clock) begin
      tapd_ff <= cmd.tap;
      prod_ff <= mac_w * mac_b;
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + 46'(prod_ff);
      end
   end

   // Shared divider operands
   logic [DIVD_W-1:0] div_n;
   logic [DIVS_W-1:0] div_d;
   logic [DIVD_W-1:0] div_q;
   logic              div_done;
   logic [45:0]       acc_mag;
   logic              sum_pos;
   logic              neg_ff, nz_ff;

   always_comb begin
      acc_mag = acc_ff[45] ? 46'(-acc_ff) : 46'(acc_ff);
      sum_pos = (cmd.div_sel == DIV_COL) ? (sy_ff > 0) : (sx_ff > 0);
      unique case (cmd.div_sel)
         DIV_SRC: begin
            div_n = {8'b0, (cmd.axis ? qy_ff : qx_ff), 1'b1, 27'b0};
            div_d = DIVS_W'(ks_in);
         end
         DIV_KSZ: begin
            div_n = DIVD_W'(1) << (6'd27 + 6'(mode));
            div_d = DIVS_W'(kscale);
         end
         DIV_ROW: begin
            div_n = DIVD_W'(acc_mag);
            div_d = sum_pos ? sx_ff[DIVS_W-1:0] : DIVS_W'(1);
         end
         default: begin
            div_n = DIVD_W'(acc_mag);
            div_d = sum_pos ? sy_ff[DIVS_W-1:0] : DIVS_W'(1);
         end
      endcase
   end

   sir_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   // Saturated quotients
   logic signed [23:0] row_sat;
   logic [PIX_W-1:0]   col_sat;

   always_comb begin
      if (!nz_ff) begin
         row_sat = '0;
      end else if (!neg_ff) begin
         row_sat = (div_q > 48'd8388607) ? 24'sh7FFFFF : $signed(div_q[23:0]);
      end else begin
         row_sat = (div_q > 48'd8388608) ? 24'sh800000 : $signed(24'd0 - div_q[23:0]);
      end
      if (!nz_ff || neg_ff) begin
         col_sat = '0;
      end else begin
         col_sat = (div_q > 48'd65535) ? 16'hFFFF : div_q[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= acc_ff[45];
         nz_ff  <= sum_pos;
      end
      if (cmd.div_take) begin
         unique case (cmd.div_sel)
            DIV_SRC: src_ff   <= div_q[30:0];
            DIV_KSZ: ksize_ff <= div_q[19:0];
            DIV_ROW: partial_ff[TIDX_W'(cmd.row)] <= row_sat;
            default: ;
         endcase
      end
   end

   // Result register and strobe
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.out_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= cmd.out_zero ? '0 : col_sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = out_ff;

   assign st.ch_bad   = ({1'b0, qch_ff} >= 3'(CHANNELS));
   assign st.div_done = div_done;
   assign st.taps_x   = tx_ff;
   assign st.taps_y   = ty_ff;

endmodule

[hw/rtl/sir_ctrl.sv]
module sir_ctrl import sir_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           kind,
   output logic           busy,
   input  sir_status_type st,
   output sir_cmd_type    cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_CHK   = 5'd1;
   localparam logic [4:0] S_SRC   = 5'd2;
   localparam logic [4:0] S_SRCW  = 5'd3;
   localparam logic [4:0] S_KSZ   = 5'd4;
   localparam logic [4:0] S_KSZW  = 5'd5;
   localparam logic [4:0] S_BEG   = 5'd6;
   localparam logic [4:0] S_W0    = 5'd7;
   localparam logic [4:0] S_W1    = 5'd8;
   localparam logic [4:0] S_W2    = 5'd9;
   localparam logic [4:0] S_W3    = 5'd10;
   localparam logic [4:0] S_W4    = 5'd11;
   localparam logic [4:0] S_RRD   = 5'd12;
   localparam logic [4:0] S_RDR1  = 5'd13;
   localparam logic [4:0] S_RDR2  = 5'd14;
   localparam logic [4:0] S_RDIV  = 5'd15;
   localparam logic [4:0] S_RDIVW = 5'd16;
   localparam logic [4:0] S_CMAC  = 5'd17;
   localparam logic [4:0] S_CDR   = 5'd18;
   localparam logic [4:0] S_CDIV  = 5'd19;
   localparam logic [4:0] S_CDIVW = 5'd20;

   logic [4:0]       state_ff, state_in;
   logic [TAP_W-1:0] k_ff, k_in;
   logic [TAP_W-1:0] j_ff, j_in;
   logic             axis_ff, axis_in;
   logic [TAP_W-1:0] taps_axis;

   assign taps_axis = axis_ff ? st.taps_y : st.taps_x;
   assign busy      = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      j_in        = j_ff;
      axis_in     = axis_ff;
      cmd         = '0;
      cmd.axis    = axis_ff;
      cmd.tap     = k_ff;
      cmd.row     = j_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.write   = !kind;
               cmd.capture = kind;
               if (kind) begin
                  state_in = S_CHK;
               end
            end
         end
         S_CHK: begin
            axis_in = 1'b0;
            if (st.ch_bad) begin
               cmd.out_load = 1'b1;
               cmd.out_zero = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_SRC;
            end
         end
         S_SRC: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SRC;
            state_in      = S_SRCW;
         end
         S_SRCW: begin
            cmd.div_sel = DIV_SRC;
            if (st.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_KSZ;
            end
         end
         S_KSZ: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_KSZ;
            state_in      = S_KSZW;
         end
         S_KSZW: begin
            cmd.div_sel = DIV_KSZ;
            if (st.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_BEG;
            end
         end
         S_BEG: begin
            cmd.begin_load = 1'b1;
            k_in           = '0;
            state_in       = S_W0;
         end
         S_W0: begin
            cmd.w_en  = 1'b1;
            cmd.wstep = WS_DIST;
            state_in  = S_W1;
         end
         S_W1: begin
            cmd.w_en  = 1'b1;
            cmd.wstep = WS_SCALE;
            state_in  = S_W2;
         end
         S_W2: begin
            cmd.w_en  = 1'b1;
            cmd.wstep = WS_SQ;
            state_in  = S_W3;
         end
         S_W3: begin
            cmd.w_en  = 1'b1;
            cmd.wstep = WS_CUBE;
            state_in  = S_W4;
         end
         S_W4: begin
            cmd.w_en  = 1'b1;
            cmd.wstep = WS_STORE;
            if (k_ff + 1'b1 == taps_axis) begin
               k_in = '0;
               if (!axis_ff) begin
                  axis_in  = 1'b1;
                  state_in = S_SRC;
               end else begin
                  j_in     = '0;
                  state_in = S_RRD;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_W0;
            end
         end
         // Issue one store read per tap of the current row
         S_RRD: begin
            cmd.rd_issue = 1'b1;
            if (k_ff + 1'b1 == st.taps_x) begin
               k_in     = '0;
               state_in = S_RDR1;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_RDR1: state_in = S_RDR2;
         S_RDR2: state_in = S_RDIV;
         S_RDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_ROW;
            state_in      = S_RDIVW;
         end
         S_RDIVW: begin
            cmd.div_sel = DIV_ROW;
            if (st.div_done) begin
               cmd.div_take = 1'b1;
               if (j_ff + 1'b1 == st.taps_y) begin
                  j_in     = '0;
                  state_in = S_CMAC;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_RRD;
               end
            end
         end
         // Column pass over the row partials
         S_CMAC: begin
            cmd.col_mac = 1'b1;
            if (j_ff + 1'b1 == st.taps_y) begin
               j_in     = '0;
               state_in = S_CDR;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_CDR: state_in = S_CDIV;
         S_CDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_COL;
            state_in      = S_CDIVW;
         end
         S_CDIVW: begin
            cmd.div_sel = DIV_COL;
            if (st.div_done) begin
               cmd.div_take = 1'b1;
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         j_ff     <= '0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
         axis_ff  <= axis_in;
      end
   end

endmodule
